// ===== sv/spq_pkg.sv =====
package spq_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 32;

  localparam logic [1:0] KIND_ENQ  = 2'd0;
  localparam logic [1:0] KIND_DEQ  = 2'd1;
  localparam logic [1:0] KIND_PEEK = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] data_in;
    logic [7:0]  priority_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] data_out;
  } out_item_t;

  typedef struct packed {
    logic                  valid;
    logic [7:0]            prio;
    logic [DATA_WIDTH-1:0] data;
  } entry_t;

  typedef struct packed {
    logic                  enq;
    logic                  deq;
    logic [7:0]            prio;
    logic [DATA_WIDTH-1:0] data;
  } cell_ctl_t;

  function automatic logic [DATA_WIDTH-1:0] to_store(input logic [31:0] d);
    logic [63:0] tmp;
    tmp = 64'(d);
    return tmp[DATA_WIDTH-1:0];
  endfunction

  function automatic logic [31:0] from_store(input logic [DATA_WIDTH-1:0] s);
    logic [63:0] tmp;
    tmp = 64'(s);
    return tmp[31:0];
  endfunction

endpackage

// ===== sv/spq_cell.sv =====
module spq_cell
  import spq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  entry_t    left_i,
  input  logic      left_disp_i,
  input  entry_t    right_i,
  output entry_t    ent_o,
  output logic      disp_o
);

  entry_t ent_r;
  entry_t ent_nxt;

  // displaced: new entry belongs at or before this position
  assign disp_o = !ent_r.valid || (ent_r.prio < ctl.prio);
  assign ent_o  = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.enq && disp_o) begin
      if (left_disp_i) begin
        ent_nxt = left_i;
      end else begin
        ent_nxt.valid = 1'b1;
        ent_nxt.prio  = ctl.prio;
        ent_nxt.data  = ctl.data;
      end
    end else if (ctl.deq) begin
      ent_nxt = right_i;
    end
  end

  always_ff @(posedge clk) begin
    ent_r.prio <= ent_nxt.prio;
    ent_r.data <= ent_nxt.data;
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else begin
      ent_r.valid <= ent_nxt.valid;
    end
  end

endmodule

// ===== sv/stable_priority_queue_top.sv =====
// Sorted priority queue of CAPACITY entries built as a row of cells, head in
// cell 0. On enqueue, dequeue or peek every cell compares its priority with
// the incoming one and either keeps, takes its left neighbor, takes the new
// entry or takes its right neighbor, all in the same edge. An item is accepted
// every cycle while results are taken; the result is registered and shows in
// the cycle after the input transfer, and in_ready drops only while a result
// waits with out_ready low. Equal priorities leave in arrival order.
module stable_priority_queue_top
  import spq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  entry_t    ent   [CAPACITY];
  logic      disp  [CAPACITY];
  entry_t    right [CAPACITY];
  entry_t    left  [CAPACITY];
  logic      ldisp [CAPACITY];
  cell_ctl_t ctl;

  logic      fire;
  logic      full;
  logic      empty;
  logic      out_valid_r;
  logic      out_valid_nxt;
  out_item_t out_item_r;
  out_item_t out_item_nxt;

  assign fire  = in_valid && in_ready;
  assign full  = ent[CAPACITY-1].valid;
  assign empty = !ent[0].valid;

  assign in_ready  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign ctl.enq  = fire && (in_item.kind == KIND_ENQ) && !full;
  assign ctl.deq  = fire && (in_item.kind == KIND_DEQ) && !empty;
  assign ctl.prio = in_item.priority_in;
  assign ctl.data = to_store(in_item.data_in);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left[i]  = '0;
      assign ldisp[i] = 1'b0;
    end else begin : g_mid
      assign left[i]  = ent[i-1];
      assign ldisp[i] = disp[i-1];
    end
    if (i == CAPACITY-1) begin : g_tail
      assign right[i] = '0;
    end else begin : g_body
      assign right[i] = ent[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .left_i     (left[i]),
      .left_disp_i(ldisp[i]),
      .right_i    (right[i]),
      .ent_o      (ent[i]),
      .disp_o     (disp[i])
    );
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (fire) begin
      out_valid_nxt         = 1'b1;
      out_item_nxt.status   = ST_OK;
      out_item_nxt.data_out = '0;
      if (in_item.kind == KIND_ENQ) begin
        if (full) begin
          out_item_nxt.status = ST_FULL;
        end
      end else if (empty) begin
        out_item_nxt.status = ST_EMPTY;
      end else begin
        out_item_nxt.data_out = from_store(ent[0].data);
      end
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== sv/spq_checker.sv =====
module spq_checker
  import spq_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("no result after input transfer");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.status == ST_OK) || (out_item.status == ST_FULL) ||
                  (out_item.status == ST_EMPTY))
    else $error("bad status code");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status != ST_OK) |-> out_item.data_out == '0)
    else $error("failed transfer carries data");

endmodule

bind stable_priority_queue_top spq_checker u_spq_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_item (out_item)
);
